// ===== hdl/chlc_pkg.sv =====
// Package for the convex hull line container: sizes, constants, state codes
// and the command and status bundles between controller and datapath.
// No dependencies.
package chlc_pkg;

    // Store size and derived index widths
    localparam int MAX_LINES = 1024;
    localparam int IDX_W     = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);

    // Field widths of a request and of a stored line
    localparam int K_IN_W  = 32;
    localparam int M_IN_W  = 48;
    localparam int X_W     = 24;
    localparam int SLOPE_W = K_IN_W + 1;
    localparam int ICPT_W  = M_IN_W + 1;
    localparam int BP_W    = 64;
    localparam int VAL_W   = 64;
    localparam int PROD_W  = SLOPE_W + X_W;
    localparam int NUM_W   = ICPT_W + 1;
    localparam int DEN_W   = SLOPE_W + 1;
    localparam int IN_DATA_W = K_IN_W + M_IN_W + X_W;

    // Breakpoint limits
    localparam logic signed [BP_W-1:0] BIG_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [BP_W-1:0] BIG_NEG = 64'sh8000_0000_0000_0001;

    // Operation codes carried in the input tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
        logic signed [BP_W-1:0]    bp;
    } line_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_INS,
        S_CR_RDA, S_CR_RDB, S_CR_CAP, S_CR_CALC, S_CR_DIV, S_CR_WR,
        S_RM_RD, S_RM_WR, S_BK_RDA, S_BK_RDB, S_BK_CMP,
        S_Q_RD, S_Q_CHK, S_Q_MUL, S_Q_SUM, S_RESP
    } state_t;

    // What follows a breakpoint update
    typedef enum logic [1:0] {PH_FWD, PH_XY, PH_FIX} phase_t;

    typedef enum logic [2:0] {
        RD_POS, RD_JM1, RD_J1, RD_A, RD_A1, RD_AM1, RD_MID, RD_LO
    } rd_src_t;

    typedef enum logic [1:0] {WR_RD_J, WR_NEW, WR_BP} wr_src_t;
    typedef enum logic [2:0] {J_HOLD, J_CNT, J_DEC, J_INC, J_A1, J_A} j_op_t;
    typedef enum logic [1:0] {A_HOLD, A_POS, A_DEC} a_op_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
    typedef enum logic [1:0] {BP_HOLD, BP_POS, BP_EQ, BP_DIV} bp_op_t;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rd_src_t rd_src;
        logic    wr_en;
        wr_src_t wr_src;
        logic    pos_clr;
        logic    pos_inc;
        j_op_t   j_op;
        a_op_t   a_op;
        cnt_op_t cnt_op;
        logic    cap_a;
        logic    cap_b;
        bp_op_t  bp_op;
        logic    div_start;
        logic    q_init;
        logic    q_step;
        logic    mul;
        logic    q_sum;
        logic    set_ovf;
        logic    set_empty;
        logic    res_load;
    } cmd_t;

    typedef struct packed {
        logic op_query;
        logic full;
        logic empty;
        logic pos_lt_cnt;
        logic slope_le_k;
        logic j_gt_pos;
        logic rm_more;
        logic a_zero;
        logic b_valid;
        logic slopes_eq;
        logic dom;
        logic bk_ge;
        logic div_done;
        logic lo_lt_hi;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/chlc_div.sv =====
// Restoring divider, one quotient bit per cycle, giving a floored quotient.
// Depends on chlc_pkg.
module chlc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [chlc_pkg::NUM_W-1:0] num,
    input  logic signed [chlc_pkg::DEN_W-1:0] den,
    output logic                           done,
    output logic signed [chlc_pkg::BP_W-1:0]  quot
);
    import chlc_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [NUM_W-1:0]    n_reg, n_next;
    logic [DEN_W-1:0]    r_reg, r_next;
    logic [DEN_W-1:0]    d_reg, d_next;
    logic                neg_reg, neg_next;
    logic [DEN_W:0]      trial;
    logic [BP_W-1:0]     q_ext;
    logic [BP_W-1:0]     q_up;

    // Shift and subtract step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        trial     = {r_reg, n_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W);
            n_next    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            d_next    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            r_next    = '0;
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DEN_W'(trial - {1'b0, d_reg});
                n_next = {n_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DEN_W-1:0];
                n_next = {n_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // Round towards minus infinity when the signs differ and a remainder is left
    assign q_ext = {{(BP_W - NUM_W){1'b0}}, n_reg};
    assign q_up  = q_ext + {{(BP_W - 1){1'b0}}, |r_reg};
    assign quot  = neg_reg ? -$signed(q_up) : $signed(q_ext);
    assign done  = done_reg;

endmodule

// ===== hdl/chlc_dp.sv =====
// Datapath of the line container: line store, index registers, divider,
// query multiplier, configuration register and result register.
// Depends on chlc_pkg and chlc_div.
module chlc_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic [chlc_pkg::IN_DATA_W-1:0]     in_data,
    input  logic                               in_user,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [chlc_pkg::VAL_W-1:0]         out_data,
    output logic [1:0]                         out_user,
    input  chlc_pkg::cmd_t                     cmd,
    output chlc_pkg::sts_t                     sts
);
    import chlc_pkg::*;

    // Line store
    line_t mem [MAX_LINES];
    line_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    line_t wr_data;

    logic                      min_mode_reg;
    logic                      op_reg, op_next;
    logic signed [SLOPE_W-1:0] k_reg, k_next;
    logic signed [ICPT_W-1:0]  m_reg, m_next;
    logic signed [X_W-1:0]     qx_reg, qx_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]          j_reg, j_next;
    logic [IDX_W-1:0]          a_reg, a_next;
    logic [IDX_W-1:0]          lo_reg, lo_next, hi_reg, hi_next;
    line_t                     a_line_reg, a_line_next;
    line_t                     b_line_reg, b_line_next;
    logic signed [BP_W-1:0]    bp_reg, bp_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [VAL_W-1:0]   sum_reg, sum_next;
    logic                      ovf_reg, ovf_next, empty_reg, empty_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]          out_val_reg, out_val_next;
    logic                      out_empty_reg, out_empty_next, out_ovf_reg, out_ovf_next;

    logic signed [K_IN_W-1:0]  slope_in;
    logic signed [M_IN_W-1:0]  icpt_in;
    logic signed [SLOPE_W-1:0] k_ext;
    logic signed [ICPT_W-1:0]  m_ext;
    logic [CNT_W-1:0]          j_m1, j_p1, a_p1;
    logic [IDX_W-1:0]          mid;
    logic signed [NUM_W-1:0]   div_num;
    logic signed [DEN_W-1:0]   div_den;
    logic                      div_done;
    logic signed [BP_W-1:0]    div_quot;
    logic signed [PROD_W-1:0]  mul_a, mul_b;
    logic                      out_free;

    assign slope_in = in_data[K_IN_W-1:0];
    assign icpt_in  = in_data[K_IN_W+M_IN_W-1:K_IN_W];
    assign k_ext    = {slope_in[K_IN_W-1], slope_in};
    assign m_ext    = {icpt_in[M_IN_W-1], icpt_in};

    assign j_m1 = j_reg - CNT_W'(1);
    assign j_p1 = j_reg + CNT_W'(1);
    assign a_p1 = {1'b0, a_reg} + CNT_W'(1);
    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_free = !out_valid_reg || out_ready;

    // Divider operands: intercept difference over slope difference
    assign div_num = {{(NUM_W - ICPT_W){b_line_reg.icpt[ICPT_W-1]}}, b_line_reg.icpt}
                   - {{(NUM_W - ICPT_W){a_line_reg.icpt[ICPT_W-1]}}, a_line_reg.icpt};
    assign div_den = {{(DEN_W - SLOPE_W){a_line_reg.slope[SLOPE_W-1]}}, a_line_reg.slope}
                   - {{(DEN_W - SLOPE_W){b_line_reg.slope[SLOPE_W-1]}}, b_line_reg.slope};

    chlc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Store addressing
    always_comb
    begin
        case (cmd.rd_src)
            RD_POS:  rd_addr = pos_reg[IDX_W-1:0];
            RD_JM1:  rd_addr = j_m1[IDX_W-1:0];
            RD_J1:   rd_addr = j_p1[IDX_W-1:0];
            RD_A:    rd_addr = a_reg;
            RD_A1:   rd_addr = a_p1[IDX_W-1:0];
            RD_AM1:  rd_addr = a_reg - IDX_W'(1);
            RD_MID:  rd_addr = mid;
            RD_LO:   rd_addr = lo_reg;
            default: rd_addr = a_reg;
        endcase
        case (cmd.wr_src)
            WR_RD_J:
            begin
                wr_addr = j_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
            end
            WR_NEW:
            begin
                wr_addr = pos_reg[IDX_W-1:0];
                wr_data = '{slope: k_reg, icpt: m_reg, bp: '0};
            end
            WR_BP:
            begin
                wr_addr = a_reg;
                wr_data = '{slope: a_line_reg.slope, icpt: a_line_reg.icpt, bp: bp_reg};
            end
            default:
            begin
                wr_addr = a_reg;
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sign-extended operands of the query product
    assign mul_a = {{(PROD_W - SLOPE_W){rd_data_reg.slope[SLOPE_W-1]}}, rd_data_reg.slope};
    assign mul_b = {{(PROD_W - X_W){qx_reg[X_W-1]}}, qx_reg};

    // Next values of the working registers
    always_comb
    begin
        op_next        = op_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        qx_next        = qx_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        a_line_next    = a_line_reg;
        b_line_next    = b_line_reg;
        bp_next        = bp_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;

        if (cmd.load_item)
        begin
            op_next    = in_user;
            k_next     = min_mode_reg ? -k_ext : k_ext;
            m_next     = min_mode_reg ? -m_ext : m_ext;
            qx_next    = in_data[IN_DATA_W-1:K_IN_W+M_IN_W];
            sum_next   = '0;
            ovf_next   = 1'b0;
            empty_next = 1'b0;
        end
        if (cmd.set_ovf)   ovf_next = 1'b1;
        if (cmd.set_empty) empty_next = 1'b1;
        if (cmd.pos_clr)   pos_next = '0;
        if (cmd.pos_inc)   pos_next = pos_reg + CNT_W'(1);

        case (cmd.j_op)
            J_CNT:   j_next = cnt_reg;
            J_DEC:   j_next = j_m1;
            J_INC:   j_next = j_p1;
            J_A1:    j_next = a_p1;
            J_A:     j_next = {1'b0, a_reg};
            default: j_next = j_reg;
        endcase
        case (cmd.a_op)
            A_POS:   a_next = pos_reg[IDX_W-1:0];
            A_DEC:   a_next = a_reg - IDX_W'(1);
            default: a_next = a_reg;
        endcase
        case (cmd.cnt_op)
            CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC: cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
        case (cmd.bp_op)
            BP_POS:  bp_next = BIG_POS;
            BP_EQ:   bp_next = (a_line_reg.icpt > b_line_reg.icpt) ? BIG_POS : BIG_NEG;
            BP_DIV:  bp_next = div_quot;
            default: bp_next = bp_reg;
        endcase

        if (cmd.cap_a) a_line_next = rd_data_reg;
        if (cmd.cap_b) b_line_next = rd_data_reg;

        // Binary search over breakpoints
        if (cmd.q_init)
        begin
            lo_next = '0;
            hi_next = IDX_W'(cnt_reg - CNT_W'(1));
        end
        if (cmd.q_step)
        begin
            if (rd_data_reg.bp >= $signed({{(BP_W - X_W){qx_reg[X_W-1]}}, qx_reg}))
                hi_next = mid;
            else
                lo_next = mid + IDX_W'(1);
        end
        if (cmd.mul)
            prod_next = mul_a * mul_b;
        if (cmd.q_sum)
            sum_next = {{(VAL_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg}
                     + {{(VAL_W - ICPT_W){a_line_reg.icpt[ICPT_W-1]}}, a_line_reg.icpt};

        // Result register
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
            out_val_next   = min_mode_reg ? VAL_W'(-sum_reg) : VAL_W'(sum_reg);
            out_empty_next = empty_reg;
            out_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mode_reg  <= 1'b1;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                min_mode_reg <= cfg_wr_data;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        k_reg         <= k_next;
        m_reg         <= m_next;
        qx_reg        <= qx_next;
        pos_reg       <= pos_next;
        j_reg         <= j_next;
        a_reg         <= a_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        a_line_reg    <= a_line_next;
        b_line_reg    <= b_line_next;
        bp_reg        <= bp_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        ovf_reg       <= ovf_next;
        empty_reg     <= empty_next;
        out_val_reg   <= out_val_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Status towards the controller
    always_comb
    begin
        sts.op_query   = (op_reg == OP_QUERY);
        sts.full       = (cnt_reg == CNT_W'(MAX_LINES));
        sts.empty      = (cnt_reg == '0);
        sts.pos_lt_cnt = (pos_reg < cnt_reg);
        sts.slope_le_k = (rd_data_reg.slope <= k_reg);
        sts.j_gt_pos   = (j_reg > pos_reg);
        sts.rm_more    = (j_p1 < cnt_reg);
        sts.a_zero     = (a_reg == '0);
        sts.b_valid    = (a_p1 < cnt_reg);
        sts.slopes_eq  = (a_line_reg.slope == b_line_reg.slope);
        sts.dom        = (a_p1 < cnt_reg) && (bp_reg >= b_line_reg.bp);
        sts.bk_ge      = (a_line_reg.bp >= rd_data_reg.bp);
        sts.div_done   = div_done;
        sts.lo_lt_hi   = (lo_reg < hi_reg);
        sts.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_val_reg;
    assign out_user  = {out_ovf_reg, out_empty_reg};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_LINES))
        else $error("line count beyond store size");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |->
            (cnt_reg == $past(cnt_reg) + CNT_W'(1)) || (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("line count moved by more than one");
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> out_free)
        else $error("result overwritten before it was taken");
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_src == WR_RD_J) |-> j_reg < CNT_W'(MAX_LINES))
        else $error("store write beyond its depth");
`endif

endmodule

// ===== hdl/chlc_ctrl.sv =====
// Controller of the line container: sequences scans, shifts, breakpoint
// updates, removals and the query search. Depends on chlc_pkg.
module chlc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  chlc_pkg::sts_t sts,
    output chlc_pkg::cmd_t cmd
);
    import chlc_pkg::*;

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (sts.op_query)
                    state_next = sts.empty ? S_RESP : S_Q_RD;
                else
                    state_next = sts.full ? S_RESP : S_SCAN_RD;
            end
            S_SCAN_RD:  state_next = sts.pos_lt_cnt ? S_SCAN_CHK : S_SH_RD;
            S_SCAN_CHK: state_next = sts.slope_le_k ? S_SCAN_RD : S_SH_RD;
            S_SH_RD:    state_next = sts.j_gt_pos ? S_SH_WR : S_INS;
            S_SH_WR:    state_next = S_SH_RD;
            S_INS:
            begin
                state_next = S_CR_RDA;
                ph_next    = PH_FWD;
            end
            S_CR_RDA:   state_next = S_CR_RDB;
            S_CR_RDB:   state_next = S_CR_CAP;
            S_CR_CAP:   state_next = S_CR_CALC;
            S_CR_CALC:
            begin
                if (!sts.b_valid || sts.slopes_eq)
                    state_next = S_CR_WR;
                else
                    state_next = S_CR_DIV;
            end
            S_CR_DIV:   if (sts.div_done) state_next = S_CR_WR;
            S_CR_WR:
            begin
                case (ph_reg)
                    PH_FWD:
                    begin
                        if (sts.dom)
                            state_next = S_RM_RD;
                        else if (!sts.a_zero)
                        begin
                            state_next = S_CR_RDA;
                            ph_next    = PH_XY;
                        end
                        else
                            state_next = S_RESP;
                    end
                    PH_XY:
                    begin
                        if (sts.dom)
                        begin
                            state_next = S_RM_RD;
                            ph_next    = PH_FIX;
                        end
                        else
                            state_next = S_BK_RDA;
                    end
                    default:    state_next = S_BK_RDA;
                endcase
            end
            S_RM_RD:    state_next = sts.rm_more ? S_RM_WR : S_CR_RDA;
            S_RM_WR:    state_next = S_RM_RD;
            S_BK_RDA:   state_next = sts.a_zero ? S_RESP : S_BK_RDB;
            S_BK_RDB:   state_next = S_BK_CMP;
            S_BK_CMP:
            begin
                if (sts.bk_ge)
                begin
                    state_next = S_RM_RD;
                    ph_next    = PH_FIX;
                end
                else
                    state_next = S_RESP;
            end
            S_Q_RD:     state_next = sts.lo_lt_hi ? S_Q_CHK : S_Q_MUL;
            S_Q_CHK:    state_next = S_Q_RD;
            S_Q_MUL:    state_next = S_Q_SUM;
            S_Q_SUM:    state_next = S_RESP;
            S_RESP:     if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:     cmd.load_item = in_valid;
            S_DECODE:
            begin
                if (sts.op_query)
                begin
                    if (sts.empty) cmd.set_empty = 1'b1;
                    else           cmd.q_init = 1'b1;
                end
                else if (sts.full)
                    cmd.set_ovf = 1'b1;
                else
                begin
                    cmd.pos_clr = 1'b1;
                    cmd.j_op    = J_CNT;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = sts.pos_lt_cnt;
                cmd.rd_src = RD_POS;
            end
            S_SCAN_CHK: cmd.pos_inc = sts.slope_le_k;
            S_SH_RD:
            begin
                cmd.rd_en  = sts.j_gt_pos;
                cmd.rd_src = RD_JM1;
            end
            S_SH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_RD_J;
                cmd.j_op   = J_DEC;
            end
            S_INS:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_NEW;
                cmd.cnt_op = CNT_INC;
                cmd.a_op   = A_POS;
            end
            S_CR_RDA:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_A;
            end
            S_CR_RDB:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_en  = sts.b_valid;
                cmd.rd_src = RD_A1;
            end
            S_CR_CAP:   cmd.cap_b = 1'b1;
            S_CR_CALC:
            begin
                if (!sts.b_valid)      cmd.bp_op = BP_POS;
                else if (sts.slopes_eq) cmd.bp_op = BP_EQ;
                else                    cmd.div_start = 1'b1;
            end
            S_CR_DIV:   if (sts.div_done) cmd.bp_op = BP_DIV;
            S_CR_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_BP;
                if ((ph_reg == PH_FWD || ph_reg == PH_XY) && sts.dom)
                    cmd.j_op = J_A1;
                else if (ph_reg == PH_FWD && !sts.a_zero)
                    cmd.a_op = A_DEC;
            end
            S_RM_RD:
            begin
                if (sts.rm_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_J1;
                end
                else
                    cmd.cnt_op = CNT_DEC;
            end
            S_RM_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_RD_J;
                cmd.j_op   = J_INC;
            end
            S_BK_RDA:
            begin
                cmd.rd_en  = !sts.a_zero;
                cmd.rd_src = RD_AM1;
            end
            S_BK_RDB:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_A;
            end
            S_BK_CMP:
            begin
                if (sts.bk_ge)
                begin
                    cmd.j_op = J_A;
                    cmd.a_op = A_DEC;
                end
            end
            S_Q_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = sts.lo_lt_hi ? RD_MID : RD_LO;
            end
            S_Q_CHK:    cmd.q_step = 1'b1;
            S_Q_MUL:
            begin
                cmd.mul   = 1'b1;
                cmd.cap_a = 1'b1;
            end
            S_Q_SUM:    cmd.q_sum = 1'b1;
            S_RESP:     cmd.res_load = sts.out_free;
            default:    cmd = '0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_FWD;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

`ifndef SYNTHESIS
    a_one_port_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("store read and written in one cycle");
    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_CR_DIV)
        else $error("divider started outside a breakpoint update");
    a_resp_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> state_reg == S_IDLE)
        else $error("result loaded without returning to idle");
`endif

endmodule

// ===== hdl/convex_hull_line_container_unit.sv =====
// A query runs a binary search over the breakpoints, then a multiply and an add, and registers its result.
// An add scans for its place, shifts the later lines up, inserts, then runs breakpoint updates (dividing
// when the slopes differ), moves entries on each removal, and makes backward checks.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: line count cleared, minimum_mode set to 1; the store is not cleared.
// Depends on chlc_pkg, chlc_ctrl and chlc_dp.
module convex_hull_line_container_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata from bit 0: slope[31:0], intercept[79:32], query_x[103:80]
    input  logic [chlc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: operation
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: envelope_value[63:0]
    output logic [chlc_pkg::VAL_W-1:0]     m_axis_tdata,
    // tuser from bit 0: store_empty, store_overflow
    output logic [1:0]                     m_axis_tuser
);
    import chlc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    chlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store and arithmetic
    chlc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .in_user     (s_axis_tuser),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata),
        .out_user    (m_axis_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for convex_hull_line_container_unit: a directed
// table, random phases in both envelope modes and a fill of the line store.
// Depends on chlc_pkg and the RTL of the unit.
module testbench;

    import chlc_pkg::*;

    typedef struct packed {
        logic signed [63:0] val;
        logic               empty;
        logic               ovf;
    } env_res_t;

    typedef struct {
        logic               op;
        logic signed [31:0] k;
        logic signed [47:0] m;
        logic signed [23:0] x;
        bit                 typed;
        env_res_t           res;
    } req_row_t;

    // Stored slopes of random lines stay below this, so the store fill wins
    localparam longint SLOPE_LIM = 64'sd2147483648 - 64'sd33554432;
    localparam longint FILL_BASE = 64'sd2147483648 - 64'sd1023;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [VAL_W-1:0]     m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    convex_hull_line_container_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted hull, held as stored (already negated in minimum mode)
    longint   hull_k  [MAX_LINES];
    longint   hull_m  [MAX_LINES];
    longint   hull_bp [MAX_LINES];
    int       hull_n = 0;
    bit       pred_min = 1'b1;

    env_res_t envelope_q [$];
    req_row_t sent_q [$];
    req_row_t dir_tab [$];
    int       errors = 0;
    bit       drv_on = 1'b0;
    int       burst_left = 1;

    function automatic longint floor_quot(longint a, longint b);
        if (b == 0)
            return 0;
        if (b < 0)
        begin
            a = -a;
            b = -b;
        end
        if (a >= 0)
            return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic void hull_drop(int i);
        for (int j = i; j + 1 < hull_n; j++)
        begin
            hull_k[j]  = hull_k[j+1];
            hull_m[j]  = hull_m[j+1];
            hull_bp[j] = hull_bp[j+1];
        end
        hull_n--;
    endfunction

    // Breakpoint of line a against b; true when b is no longer on the hull
    function automatic bit hull_cross(int a, int b);
        if (b >= hull_n)
        begin
            hull_bp[a] = BIG_POS;
            return 1'b0;
        end
        if (hull_k[a] == hull_k[b])
            hull_bp[a] = (hull_m[a] > hull_m[b]) ? BIG_POS : BIG_NEG;
        else
            hull_bp[a] = floor_quot(hull_m[b] - hull_m[a], hull_k[a] - hull_k[b]);
        return hull_bp[a] >= hull_bp[b];
    endfunction

    function automatic void hull_insert(longint k, longint m);
        int pos;
        int x;
        int y;
        pos = 0;
        while (pos < hull_n && hull_k[pos] <= k)
            pos++;
        for (int j = hull_n; j > pos; j--)
        begin
            hull_k[j]  = hull_k[j-1];
            hull_m[j]  = hull_m[j-1];
            hull_bp[j] = hull_bp[j-1];
        end
        hull_k[pos]  = k;
        hull_m[pos]  = m;
        hull_bp[pos] = 0;
        hull_n++;
        y = pos;
        while (hull_cross(y, y + 1))
            hull_drop(y + 1);
        x = y;
        if (x != 0)
        begin
            x--;
            if (hull_cross(x, y))
            begin
                hull_drop(y);
                void'(hull_cross(x, x + 1));
            end
        end
        while (x != 0)
        begin
            y = x;
            x = y - 1;
            if (hull_bp[x] >= hull_bp[y])
            begin
                hull_drop(y);
                void'(hull_cross(x, x + 1));
            end
            else
                break;
        end
    endfunction

    // Expected result of one request, updating the predicted hull
    function automatic env_res_t hull_step(logic op, longint k, longint m, longint x);
        env_res_t r;
        int       lo;
        int       hi;
        int       mid;
        longint   v;
        r = '0;
        if (op == OP_ADD)
        begin
            if (hull_n >= MAX_LINES)
                r.ovf = 1'b1;
            else if (pred_min)
                hull_insert(-k, -m);
            else
                hull_insert(k, m);
        end
        else if (hull_n == 0)
            r.empty = 1'b1;
        else
        begin
            lo = 0;
            hi = hull_n - 1;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (hull_bp[mid] >= x)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            v = hull_k[lo] * x + hull_m[lo];
            r.val = pred_min ? -v : v;
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // Watch both handshakes: predict on each request, check each result
    always @(posedge clk)
    begin
        req_row_t row;
        env_res_t want;
        env_res_t pred;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pred = hull_step(s_axis_tuser, longint'($signed(s_axis_tdata[31:0])),
                             longint'($signed(s_axis_tdata[79:32])),
                             longint'($signed(s_axis_tdata[103:80])));
            row = sent_q.pop_front();
            envelope_q.insert(envelope_q.size(), row.typed ? row.res : pred);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (envelope_q.size() == 0)
                report("unexpected result", m_axis_tdata, 0);
            else
            begin
                want = envelope_q.pop_front();
                if (m_axis_tdata !== want.val)
                    report("envelope_value", m_axis_tdata, want.val);
                if (m_axis_tuser[0] !== want.empty)
                    report("store_empty", longint'(m_axis_tuser[0]), longint'(want.empty));
                if (m_axis_tuser[1] !== want.ovf)
                    report("store_overflow", longint'(m_axis_tuser[1]), longint'(want.ovf));
            end
        end
    end

    // Receiver back-pressure: stretches of full rate, light, heavy and long stalls
    int rdy_mode = 0;
    int rdy_left = 0;
    always @(posedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(20, 300);
        end
        rdy_left--;
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rdy_left % 50 > 40);
        endcase
    end

    task automatic idle_sender();
        if (drv_on)
        begin
            s_axis_tvalid <= 1'b0;
            drv_on = 1'b0;
        end
    endtask

    // Drive one request and hold it until accepted, then maybe pause
    task automatic send_req(req_row_t row);
        sent_q.insert(sent_q.size(), row);
        s_axis_tvalid <= 1'b1;
        drv_on = 1'b1;
        s_axis_tuser  <= row.op;
        s_axis_tdata  <= {row.x, row.m, row.k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            idle_sender();
            repeat ($urandom_range(1, 30))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        idle_sender();
        @(posedge clk);
        while (envelope_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_mode(bit v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pred_min = v;
    endtask

    function automatic req_row_t row_of(logic op, longint k, longint m, longint x,
                                        bit typed, longint val, bit empty);
        req_row_t r;
        r.op = op;
        r.k = 32'(k);
        r.m = 48'(m);
        r.x = 24'(x);
        r.typed = typed;
        r.res.val = val;
        r.res.empty = empty;
        r.res.ovf = 1'b0;
        return r;
    endfunction

    // Random field value: small, medium or full width
    function automatic longint pick(int w);
        longint v;
        case ($urandom_range(0, 2))
            0: v = $signed($urandom_range(0, 16)) - 8;
            1: v = $signed($urandom_range(0, 2000)) - 1000;
            default: v = longint'({$urandom, $urandom});
        endcase
        v = v <<< (64 - w);
        return v >>> (64 - w);
    endfunction

    initial
    begin
        req_row_t r;
        longint   k;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, in the reset mode (minimum)
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, 0, 1, 0, 1));
        dir_tab.insert(dir_tab.size(), row_of(OP_ADD, 0, 5, 0, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, -1, -1, 8388607, 1, 5, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_ADD, 0, 3, -1, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, -8388608, 1, 3, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_ADD, 0, 9, 0, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, 0, 1, 3, 0));
        dir_tab.insert(dir_tab.size(),
                       row_of(OP_ADD, 2147483647, -140737488355328, 0, 1, 0, 0));
        dir_tab.insert(dir_tab.size(),
                       row_of(OP_ADD, -2080374784, 140737488355327, 0, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, -8388608, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, 8388607, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, 0, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_ADD, 1, -1, -1, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_ADD, -1, -1, 0, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_ADD, 1, -1, 0, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, 1, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, -1, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_ADD, 2, 0, 0, 1, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, -2, 0, 0, 0));
        dir_tab.insert(dir_tab.size(), row_of(OP_QUERY, 0, 0, 5, 0, 0, 0));
        foreach (dir_tab[i])
            send_req(dir_tab[i]);

        // Random phases; stored lines keep their sign across mode changes
        for (int ph = 0; ph < 4; ph++)
        begin
            set_mode(ph % 2 == 0 ? 1'b0 : 1'b1);
            for (int n = 0; n < 40; n++)
            begin
                k = pick(32);
                if (!pred_min && k > SLOPE_LIM)
                    k = k - 64'sd67108864;
                if (pred_min && k < -SLOPE_LIM)
                    k = k + 64'sd67108864;
                r = row_of(1'($urandom_range(0, 1)), k, pick(48), pick(24), 0, 0, 0);
                send_req(r);
            end
        end

        // Fill the store with lines that all stay on the hull, then overflow it
        set_mode(1'b1);
        for (int i = 0; i < 1024 && hull_n < MAX_LINES; i++)
        begin
            r = row_of(OP_ADD, -(FILL_BASE + i), longint'(i) * i * 64'sd134217728,
                       pick(24), 0, 0, 0);
            send_req(r);
            wait_drained();
        end
        send_req(row_of(OP_ADD, pick(32), pick(48), pick(24), 0, 0, 0));
        send_req(row_of(OP_QUERY, pick(32), pick(48), pick(24), 0, 0, 0));
        send_req(row_of(OP_QUERY, 0, 0, 8388607, 0, 0, 0));
        set_mode(1'b0);
        send_req(row_of(OP_QUERY, 0, 0, -8388608, 0, 0, 0));

        wait_drained();
        repeat (200)
            @(posedge clk);
        if (errors == 0 && envelope_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
